// ===== rtl/bcpt_pkg.sv =====
// Shared types, register indexes and helper functions of the boundary cell portal test.
// No dependencies; every other file of the block imports this package.
package bcpt_pkg;

  // Field widths
  localparam int CW = 32;  // centre, plane and point, Q23.8 signed
  localparam int EW = 31;  // half extent and gap, Q23.8 unsigned
  localparam int MW = 6;   // face mask
  localparam int FW = 3;   // face index
  localparam int XW = 33;  // cell edge, centre sum
  localparam int DW = 34;  // edge minus plane
  localparam int IW = 2;   // configuration register index

  // Configuration register indexes
  localparam logic [IW-1:0] REG_FACE  = 2'd0;
  localparam logic [IW-1:0] REG_PLANE = 2'd1;
  localparam logic [IW-1:0] REG_GAP   = 2'd2;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Largest valid face index
  localparam logic [FW-1:0] FACE_LAST = 3'd5;

  // Edges of both cells and the centre sum on one in-plane axis
  typedef struct packed {
    logic signed [XW-1:0] a_lo;
    logic signed [XW-1:0] a_hi;
    logic signed [XW-1:0] b_lo;
    logic signed [XW-1:0] b_hi;
    logic signed [XW-1:0] sum;
  } span_t;

  // Both cells' faces on the plane axis
  typedef struct packed {
    logic signed [XW-1:0] a_lo;
    logic signed [XW-1:0] a_hi;
    logic signed [XW-1:0] b_lo;
    logic signed [XW-1:0] b_hi;
  } face_t;

  // Overlap result, shared span and midpoint on one in-plane axis
  typedef struct packed {
    logic                 hit;
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] mid;
  } span_res_t;

  typedef struct packed {
    logic        mask_ok;
    logic [1:0]  axis;
    span_t       sp1;
    span_t       sp2;
    face_t       fc;
  } s1_t;

  typedef struct packed {
    logic                 mask_ok;
    logic [1:0]           axis;
    span_res_t            r1;
    span_res_t            r2;
    logic signed [DW-1:0] d_alo;
    logic signed [DW-1:0] d_ahi;
    logic signed [DW-1:0] d_blo;
    logic signed [DW-1:0] d_bhi;
  } s2_t;

  typedef struct packed {
    logic                 ok_pre;
    logic [1:0]           axis;
    logic signed [CW-1:0] pt1;
    logic signed [CW-1:0] pt2;
    logic [DW-1:0]        near_a;
    logic [DW-1:0]        near_b;
  } s3_t;

  // Next axis in the cycle x, y, z
  function automatic logic [1:0] next_axis(input logic [1:0] a);
    logic [1:0] r;
    case (a)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      AXIS_Z:  r = AXIS_X;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction

  // Pick one coordinate of a point by axis
  function automatic logic signed [CW-1:0] pick(input logic [1:0] a,
                                                 input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y,
                                                 input logic signed [CW-1:0] z);
    logic signed [CW-1:0] r;
    case (a)
      AXIS_X:  r = x;
      AXIS_Y:  r = y;
      AXIS_Z:  r = z;
      default: r = x;
    endcase
    return r;
  endfunction

  // Magnitude of a signed distance
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // Clamp a midpoint into the shared span; the result fits the point width
  function automatic logic signed [CW-1:0] clamp(input logic signed [XW-1:0] m,
                                                  input logic signed [XW-1:0] lo,
                                                  input logic signed [XW-1:0] hi);
    logic signed [XW-1:0] r;
    if (m < lo) begin
      r = lo;
    end else if (m > hi) begin
      r = hi;
    end else begin
      r = m;
    end
    return r[CW-1:0];
  endfunction

endpackage

// ===== rtl/bcpt_prep.sv =====
// Front stage logic: picks the plane axis and the two in-plane axes, forms cell edges.
// Depends on bcpt_pkg.
module bcpt_prep
  import bcpt_pkg::*;
(
  input  logic [FW-1:0]        face_index,
  input  logic signed [CW-1:0] a_center_x,
  input  logic signed [CW-1:0] a_center_y,
  input  logic signed [CW-1:0] a_center_z,
  input  logic [EW-1:0]        a_extent,
  input  logic [MW-1:0]        a_face_mask,
  input  logic signed [CW-1:0] b_center_x,
  input  logic signed [CW-1:0] b_center_y,
  input  logic signed [CW-1:0] b_center_z,
  input  logic [EW-1:0]        b_extent,
  input  logic [MW-1:0]        b_face_mask,
  output s1_t                  s1
);

  logic [1:0]           axis;
  logic [1:0]           f1;
  logic [1:0]           f2;
  logic [FW-1:0]        opp;
  logic [7:0]           ma8;
  logic [7:0]           mb8;
  logic signed [XW-1:0] ea;
  logic signed [XW-1:0] eb;
  logic signed [XW-1:0] a_pl, a_i1, a_i2, b_pl, b_i1, b_i2;

  // Route coordinates by axis
  always_comb begin
    axis = face_index[2:1];
    f1   = next_axis(axis);
    f2   = next_axis(f1);
    opp  = face_index ^ FW'(1);
    ma8  = {2'b00, a_face_mask};
    mb8  = {2'b00, b_face_mask};
    ea   = $signed({2'b00, a_extent});
    eb   = $signed({2'b00, b_extent});
    a_pl = XW'(pick(axis, a_center_x, a_center_y, a_center_z));
    a_i1 = XW'(pick(f1, a_center_x, a_center_y, a_center_z));
    a_i2 = XW'(pick(f2, a_center_x, a_center_y, a_center_z));
    b_pl = XW'(pick(axis, b_center_x, b_center_y, b_center_z));
    b_i1 = XW'(pick(f1, b_center_x, b_center_y, b_center_z));
    b_i2 = XW'(pick(f2, b_center_x, b_center_y, b_center_z));
  end

  // Form edges, sums and the face mask check; a face index past five never connects
  always_comb begin
    s1.mask_ok  = (face_index <= FACE_LAST) && ma8[face_index] && mb8[opp];
    s1.axis     = axis;
    s1.sp1.a_lo = a_i1 - ea;
    s1.sp1.a_hi = a_i1 + ea;
    s1.sp1.b_lo = b_i1 - eb;
    s1.sp1.b_hi = b_i1 + eb;
    s1.sp1.sum  = a_i1 + b_i1;
    s1.sp2.a_lo = a_i2 - ea;
    s1.sp2.a_hi = a_i2 + ea;
    s1.sp2.b_lo = b_i2 - eb;
    s1.sp2.b_hi = b_i2 + eb;
    s1.sp2.sum  = a_i2 + b_i2;
    s1.fc.a_lo  = a_pl - ea;
    s1.fc.a_hi  = a_pl + ea;
    s1.fc.b_lo  = b_pl - eb;
    s1.fc.b_hi  = b_pl + eb;
  end

endmodule

// ===== rtl/bcpt_span.sv =====
// Second stage logic for one in-plane axis: overlap test, shared span and midpoint.
// Depends on bcpt_pkg.
module bcpt_span
  import bcpt_pkg::*;
(
  input  span_t     sp,
  output span_res_t res
);

  logic signed [XW-1:0] a_lo, a_hi, b_lo, b_hi, sum;

  // Compare edges, take the span both cells cover, halve the sum toward minus infinity
  always_comb begin
    a_lo    = sp.a_lo;
    a_hi    = sp.a_hi;
    b_lo    = sp.b_lo;
    b_hi    = sp.b_hi;
    sum     = sp.sum;
    res.hit = (a_hi >= b_lo) && (a_lo <= b_hi);
    res.lo  = (a_lo > b_lo) ? a_lo : b_lo;
    res.hi  = (a_hi < b_hi) ? a_hi : b_hi;
    res.mid = sum >>> 1;
  end

endmodule

// ===== rtl/boundary_cell_portal_test.sv =====
// Top level of the boundary cell portal test: config registers and a four-register pipeline.
// Depends on bcpt_pkg, bcpt_prep and bcpt_span.
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid/in_ready   | two cells: centres, extents, face masks
//  out_    | result    | out_valid/out_ready | connects flag, point x/y/z
//  cfg_    | write     | cfg_we              | cfg_index, cfg_wdata
//
// One request per cycle unless output stalls; each result passes all four registers in turn.
// Stages: edge forming, span compare and plane distance, clamp and near face, gap test.
// Each stage holds while the one after it is full and stalled; empty stages fill on.
// Reset (rst_n low, synchronous) empties the pipeline and clears all config registers.
module boundary_cell_portal_test
  import bcpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [IW-1:0]        cfg_index,
  input  logic [CW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_a_center_x,
  input  logic signed [CW-1:0] in_a_center_y,
  input  logic signed [CW-1:0] in_a_center_z,
  input  logic [EW-1:0]        in_a_extent,
  input  logic [MW-1:0]        in_a_face_mask,
  input  logic signed [CW-1:0] in_b_center_x,
  input  logic signed [CW-1:0] in_b_center_y,
  input  logic signed [CW-1:0] in_b_center_z,
  input  logic [EW-1:0]        in_b_extent,
  input  logic [MW-1:0]        in_b_face_mask,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_connects,
  output logic signed [CW-1:0] out_point_x,
  output logic signed [CW-1:0] out_point_y,
  output logic signed [CW-1:0] out_point_z
);

  logic [FW-1:0]        face_index_r;
  logic signed [CW-1:0] plane_value_r;
  logic [EW-1:0]        max_gap_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  s1_t s1_nxt, s1_r;
  s2_t s2_nxt, s2_r;
  s3_t s3_nxt, s3_r;

  logic                 connects_nxt, connects_r;
  logic signed [CW-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [CW-1:0] px_r, py_r, pz_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_index_r  <= '0;
      plane_value_r <= '0;
      max_gap_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FACE:  face_index_r  <= cfg_wdata[FW-1:0];
        REG_PLANE: plane_value_r <= $signed(cfg_wdata);
        REG_GAP:   max_gap_r     <= cfg_wdata[EW-1:0];
        default:   ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: axis routing and edges
  bcpt_prep u_prep (
    .face_index  (face_index_r),
    .a_center_x  (in_a_center_x),
    .a_center_y  (in_a_center_y),
    .a_center_z  (in_a_center_z),
    .a_extent    (in_a_extent),
    .a_face_mask (in_a_face_mask),
    .b_center_x  (in_b_center_x),
    .b_center_y  (in_b_center_y),
    .b_center_z  (in_b_center_z),
    .b_extent    (in_b_extent),
    .b_face_mask (in_b_face_mask),
    .s1          (s1_nxt)
  );

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1_r <= s1_nxt;
  end

  // Stage 2: span compares and face-to-plane differences
  span_res_t r1, r2;
  logic signed [DW-1:0] plane_ext;

  bcpt_span u_span1 (.sp(s1_r.sp1), .res(r1));
  bcpt_span u_span2 (.sp(s1_r.sp2), .res(r2));

  always_comb begin
    plane_ext      = DW'(plane_value_r);
    s2_nxt.mask_ok = s1_r.mask_ok;
    s2_nxt.axis    = s1_r.axis;
    s2_nxt.r1      = r1;
    s2_nxt.r2      = r2;
    s2_nxt.d_alo   = DW'(s1_r.fc.a_lo) - plane_ext;
    s2_nxt.d_ahi   = DW'(s1_r.fc.a_hi) - plane_ext;
    s2_nxt.d_blo   = DW'(s1_r.fc.b_lo) - plane_ext;
    s2_nxt.d_bhi   = DW'(s1_r.fc.b_hi) - plane_ext;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) s2_r <= s2_nxt;
  end

  // Stage 3: clamp midpoints, take the nearer face of each cell
  logic [DW-1:0] m_alo, m_ahi, m_blo, m_bhi;

  always_comb begin
    m_alo         = mag(s2_r.d_alo);
    m_ahi         = mag(s2_r.d_ahi);
    m_blo         = mag(s2_r.d_blo);
    m_bhi         = mag(s2_r.d_bhi);
    s3_nxt.ok_pre = s2_r.mask_ok && s2_r.r1.hit && s2_r.r2.hit;
    s3_nxt.axis   = s2_r.axis;
    s3_nxt.pt1    = clamp(s2_r.r1.mid, s2_r.r1.lo, s2_r.r1.hi);
    s3_nxt.pt2    = clamp(s2_r.r2.mid, s2_r.r2.lo, s2_r.r2.hi);
    s3_nxt.near_a = (m_alo < m_ahi) ? m_alo : m_ahi;
    s3_nxt.near_b = (m_blo < m_bhi) ? m_blo : m_bhi;
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) s3_r <= s3_nxt;
  end

  // Stage 4: gap test and point assembly; drop the point when not connected
  logic [DW-1:0]        gap_ext;
  logic [1:0]           f1;
  logic signed [CW-1:0] c_ax, c_f1, c_f2;

  always_comb begin
    gap_ext      = DW'(max_gap_r);
    f1           = next_axis(s3_r.axis);
    connects_nxt = s3_r.ok_pre && (s3_r.near_a <= gap_ext) && (s3_r.near_b <= gap_ext);
    c_ax         = connects_nxt ? plane_value_r : '0;
    c_f1         = connects_nxt ? s3_r.pt1 : '0;
    c_f2         = connects_nxt ? s3_r.pt2 : '0;
    px_nxt       = (s3_r.axis == AXIS_X) ? c_ax : ((f1 == AXIS_X) ? c_f1 : c_f2);
    py_nxt       = (s3_r.axis == AXIS_Y) ? c_ax : ((f1 == AXIS_Y) ? c_f1 : c_f2);
    pz_nxt       = (s3_r.axis == AXIS_Z) ? c_ax : ((f1 == AXIS_Z) ? c_f1 : c_f2);
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      connects_r <= connects_nxt;
      px_r       <= px_nxt;
      py_r       <= py_nxt;
      pz_r       <= pz_nxt;
    end
  end

  assign out_valid    = v4_r;
  assign out_connects = connects_r;
  assign out_point_x  = px_r;
  assign out_point_y  = py_r;
  assign out_point_z  = pz_r;

endmodule

// ===== rtl/bcpt_chk.sv =====
// Port-level checker for the boundary cell portal test, bound to the top level.
// Depends on bcpt_pkg and boundary_cell_portal_test.
module bcpt_chk
  import bcpt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_connects,
  input logic signed [CW-1:0] out_point_x,
  input logic signed [CW-1:0] out_point_y,
  input logic signed [CW-1:0] out_point_z
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_connects)
      && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z))
    else $error("stalled result changed");

  // A pair that does not connect reports a zero point
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_connects |-> out_point_x == '0 && out_point_y == '0
      && out_point_z == '0)
    else $error("nonzero point without connection");

  // An empty output stage lets the whole pipeline take a request
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind boundary_cell_portal_test bcpt_chk u_bcpt_chk (.*);

// ===== bench/testbench.sv =====
// Testbench for boundary_cell_portal_test: sends cell pairs under changing register
// settings and checks every portal result, in order, against a planned or predicted value.
// Depends on bcpt_pkg and the block's RTL.
module testbench;
  import bcpt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 60;
  localparam int IDLE_MAX    = 8;
  localparam int SHOWN_MAX   = 10;

  // Face codes; the last two name no face
  localparam logic [FW-1:0] FACE_PX     = 3'd0;
  localparam logic [FW-1:0] FACE_NX     = 3'd1;
  localparam logic [FW-1:0] FACE_PY     = 3'd2;
  localparam logic [FW-1:0] FACE_NY     = 3'd3;
  localparam logic [FW-1:0] FACE_PZ     = 3'd4;
  localparam logic [FW-1:0] FACE_NZ     = 3'd5;
  localparam logic [FW-1:0] FACE_NONE_A = 3'd6;
  localparam logic [FW-1:0] FACE_NONE_B = 3'd7;

  // Index with no register behind it
  localparam logic [IW-1:0] REG_SPARE = 2'd3;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [EW-1:0]        E_MAX = '1;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic [EW-1:0]        a_ext;
    logic [MW-1:0]        a_mask;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic [EW-1:0]        b_ext;
    logic [MW-1:0]        b_mask;
  } cell_pair_t;

  typedef struct packed {
    logic                 connects;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } portal_t;

  localparam portal_t NO_PORTAL = '0;

  typedef struct {
    bit                   set_cfg;
    logic [FW-1:0]        face;
    logic signed [CW-1:0] plane;
    logic [EW-1:0]        gap;
    cell_pair_t           pair;
    bit                   known;
    portal_t              want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IW-1:0]        cfg_index = '0;
  logic [CW-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_a_center_x = '0;
  logic signed [CW-1:0] in_a_center_y = '0;
  logic signed [CW-1:0] in_a_center_z = '0;
  logic [EW-1:0]        in_a_extent = '0;
  logic [MW-1:0]        in_a_face_mask = '0;
  logic signed [CW-1:0] in_b_center_x = '0;
  logic signed [CW-1:0] in_b_center_y = '0;
  logic signed [CW-1:0] in_b_center_z = '0;
  logic [EW-1:0]        in_b_extent = '0;
  logic [MW-1:0]        in_b_face_mask = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_connects;
  logic signed [CW-1:0] out_point_x;
  logic signed [CW-1:0] out_point_y;
  logic signed [CW-1:0] out_point_z;

  // Register copies seen by the predictor
  logic [FW-1:0]        face_reg = '0;
  logic signed [CW-1:0] plane_reg = '0;
  logic [EW-1:0]        gap_reg = '0;

  portal_t     expected_portals[$];
  plan_row_t   directed_plan[$];
  plan_row_t   staged = '{set_cfg: 1'b0, default: '0};
  bit          calm = 1'b0;
  int unsigned failures = 0;
  int unsigned results_seen = 0;
  int unsigned portals_found = 0;
  int unsigned settings_used = 0;
  int unsigned requests_sent = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  boundary_cell_portal_test DUT (.*);

  always #5 clk = ~clk;

  // Idle cycles before the next request or result; none in calm stretches
  function automatic int unsigned draw_idle();
    return calm ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  function automatic bit spans_meet(longint ca, longint ea, longint cb, longint eb);
    return (ca + ea >= cb - eb) && (ca - ea <= cb + eb);
  endfunction

  // Distance of the nearer face on the plane axis from the plane
  function automatic longint plane_offset(longint c, longint e, longint p);
    longint lo_d, hi_d;
    lo_d = c - e - p;
    hi_d = c + e - p;
    if (lo_d < 0) lo_d = -lo_d;
    if (hi_d < 0) hi_d = -hi_d;
    return (lo_d < hi_d) ? lo_d : hi_d;
  endfunction

  // Floor of the centre midpoint, held inside the span both cells cover
  function automatic longint mid_in_span(longint ca, longint ea, longint cb, longint eb);
    longint lo, hi, m;
    lo = (ca - ea > cb - eb) ? ca - ea : cb - eb;
    hi = (ca + ea < cb + eb) ? ca + ea : cb + eb;
    m = (ca + cb) >>> 1;
    if (m < lo) return lo;
    if (m > hi) return hi;
    return m;
  endfunction

  function automatic portal_t predict_portal(cell_pair_t p);
    portal_t r;
    longint  ca[3], cb[3], pt[3];
    longint  ea, eb, pl, gp;
    int      ax, u, v;
    bit      ok;
    r = NO_PORTAL;
    if (face_reg > FACE_LAST) return r;
    ca[0] = $signed(p.a_x);
    ca[1] = $signed(p.a_y);
    ca[2] = $signed(p.a_z);
    cb[0] = $signed(p.b_x);
    cb[1] = $signed(p.b_y);
    cb[2] = $signed(p.b_z);
    ea = p.a_ext;
    eb = p.b_ext;
    pl = plane_reg;
    gp = gap_reg;
    ax = int'(face_reg) / 2;
    u = (ax + 1) % 3;
    v = (ax + 2) % 3;
    ok = p.a_mask[face_reg] && p.b_mask[face_reg ^ 3'b001]
      && spans_meet(ca[u], ea, cb[u], eb) && spans_meet(ca[v], ea, cb[v], eb)
      && plane_offset(ca[ax], ea, pl) <= gp && plane_offset(cb[ax], eb, pl) <= gp;
    if (ok) begin
      pt[ax] = pl;
      pt[u] = mid_in_span(ca[u], ea, cb[u], eb);
      pt[v] = mid_in_span(ca[v], ea, cb[v], eb);
      r.connects = 1'b1;
      r.x = CW'(pt[0]);
      r.y = CW'(pt[1]);
      r.z = CW'(pt[2]);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat32(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return CW'(v);
  endfunction

  function automatic longint pick_extent();
    case ($urandom_range(0, 9))
      0: begin
        return longint'($urandom_range(0, 32'h7fff_ffff));
      end
      1: begin
        return 0;
      end
      default: begin
        return longint'($urandom_range(0, 8192));
      end
    endcase
  endfunction

  // Pair placed across the current plane with nearby spans, or pure noise
  function automatic cell_pair_t make_pair(bit noise);
    cell_pair_t    p;
    longint        ca[3], cb[3];
    longint        ea, eb, pl, g, lim, base;
    logic [FW-1:0] fc;
    int            ax;
    p.a_x = $urandom;
    p.a_y = $urandom;
    p.a_z = $urandom;
    p.a_ext = EW'($urandom);
    p.a_mask = MW'($urandom);
    p.b_x = $urandom;
    p.b_y = $urandom;
    p.b_z = $urandom;
    p.b_ext = EW'($urandom);
    p.b_mask = MW'($urandom);
    if (noise) return p;
    fc = (face_reg > FACE_LAST) ? FACE_PX : face_reg;
    ax = int'(fc) / 2;
    ea = pick_extent();
    eb = pick_extent();
    pl = plane_reg;
    g = gap_reg;
    if (g > 4096) g = 4096;
    for (int i = 0; i < 3; i++) begin
      if (i == ax) begin
        ca[i] = fc[0] ? pl + ea : pl - ea;
        cb[i] = fc[0] ? pl - eb : pl + eb;
        ca[i] += longint'($urandom_range(0, 2 * g + 2)) - g - 1;
        cb[i] += longint'($urandom_range(0, 2 * g + 2)) - g - 1;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          base = $signed($urandom);
        end else begin
          base = longint'($urandom_range(0, 65536)) - 32768;
        end
        lim = ea + eb + 64;
        if (lim > 64'sd1073741824) lim = 64'sd1073741824;
        ca[i] = base;
        cb[i] = base + longint'($urandom_range(0, 2 * lim)) - lim;
      end
    end
    p.a_x = sat32(ca[0]);
    p.a_y = sat32(ca[1]);
    p.a_z = sat32(ca[2]);
    p.b_x = sat32(cb[0]);
    p.b_y = sat32(cb[1]);
    p.b_z = sat32(cb[2]);
    p.a_ext = EW'(ea);
    p.b_ext = EW'(eb);
    if ($urandom_range(0, 9) != 0) p.a_mask[fc] = 1'b1;
    if ($urandom_range(0, 9) != 0) p.b_mask[fc ^ 3'b001] = 1'b1;
    return p;
  endfunction

  function automatic cell_pair_t cells(
    logic signed [CW-1:0] ax, logic signed [CW-1:0] ay, logic signed [CW-1:0] az,
    logic [EW-1:0] ae, logic [MW-1:0] am,
    logic signed [CW-1:0] bx, logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
    logic [EW-1:0] be, logic [MW-1:0] bm);
    return '{ax, ay, az, ae, am, bx, by, bz, be, bm};
  endfunction

  function automatic portal_t portal_at(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z);
    return '{1'b1, x, y, z};
  endfunction

  // Stage a register setting for the next planned pair
  function automatic void plan_setting(logic [FW-1:0] face, logic signed [CW-1:0] plane,
                                       logic [EW-1:0] gap);
    staged.set_cfg = 1'b1;
    staged.face = face;
    staged.plane = plane;
    staged.gap = gap;
  endfunction

  function automatic void plan_pair(cell_pair_t p, bit known, portal_t want);
    staged.pair = p;
    staged.known = known;
    staged.want = want;
    directed_plan.push_back(staged);
    staged.set_cfg = 1'b0;
  endfunction

  // Present one request, hold it until accepted, then log its expected result
  task automatic send_request(input cell_pair_t p, input portal_t want);
    int unsigned idle;
    idle = draw_idle();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_a_center_x <= p.a_x;
    in_a_center_y <= p.a_y;
    in_a_center_z <= p.a_z;
    in_a_extent <= p.a_ext;
    in_a_face_mask <= p.a_mask;
    in_b_center_x <= p.b_x;
    in_b_center_y <= p.b_y;
    in_b_center_z <= p.b_z;
    in_b_extent <= p.b_ext;
    in_b_face_mask <= p.b_mask;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_portals.push_back(want);
    requests_sent++;
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_portals.size() != 0);
  endtask

  task automatic put_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_FACE: begin
        face_reg = data[FW-1:0];
      end
      REG_PLANE: begin
        plane_reg = data;
      end
      REG_GAP: begin
        gap_reg = data[EW-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Write all registers; unused upper bits and the spare index carry noise
  task automatic write_config(input logic [FW-1:0] face, input logic signed [CW-1:0] plane,
                              input logic [EW-1:0] gap);
    logic [CW-1:0] word;
    word = $urandom;
    word[FW-1:0] = face;
    put_reg(REG_FACE, word);
    put_reg(REG_PLANE, plane);
    word = {1'($urandom), gap};
    put_reg(REG_GAP, word);
    put_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result side: stall a random number of cycles after each result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) stall_left = draw_idle();
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    portal_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_connects, out_point_x, out_point_y, out_point_z};
      if (expected_portals.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MAX)
          $display("unexpected result: connects %0b point (%0d, %0d, %0d)",
                   got.connects, got.x, got.y, got.z);
      end else begin
        want = expected_portals.pop_front();
        results_seen++;
        if (want.connects) portals_found++;
        if (got.connects !== want.connects || got.x !== want.x ||
            got.y !== want.y || got.z !== want.z) begin
          failures++;
          if (failures <= SHOWN_MAX)
            $display("result %0d mismatch: expected %0b (%0d, %0d, %0d) got %0b (%0d, %0d, %0d)",
                     results_seen, want.connects, want.x, want.y, want.z,
                     got.connects, got.x, got.y, got.z);
        end
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cell_pair_t           p;
    portal_t              want;
    logic [FW-1:0]        face;
    logic signed [CW-1:0] plane;
    logic [EW-1:0]        gap;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: face maxX, plane 0, gap 0
    plan_pair(cells(-256, 0, 0, 256, 6'b000001, 256, 0, 0, 256, 6'b000010), 1, portal_at(0, 0, 0));
    plan_pair(cells(-256, 0, 0, 256, 6'b111110, 256, 0, 0, 256, 6'b111111), 1, NO_PORTAL);
    plan_pair(cells(-256, 0, 0, 256, 6'b111111, 256, 0, 0, 256, 6'b111101), 1, NO_PORTAL);
    plan_pair(cells(-256, 0, 0, 256, 6'b000000, 256, 0, 0, 256, 6'b000000), 1, NO_PORTAL);
    plan_pair(cells(-256, 0, 0, 256, 6'b111111, 256, 0, 0, 256, 6'b111111), 1, portal_at(0, 0, 0));
    // near face one step outside a zero gap
    plan_pair(cells(-512, 0, 0, 256, 6'b000001, 256, 0, 0, 256, 6'b000010), 1, NO_PORTAL);
    // spans apart, then touching edges on y and z
    plan_pair(cells(-256, 0, 0, 256, 6'b000001, 256, 1000, 0, 256, 6'b000010), 1, NO_PORTAL);
    plan_pair(cells(-256, 0, 0, 256, 6'b000001, 256, 512, 0, 256, 6'b000010), 1,
              portal_at(0, 256, 0));
    plan_pair(cells(-256, 0, 0, 256, 6'b000001, 256, 0, -512, 256, 6'b000010), 1,
              portal_at(0, 0, -256));
    // odd negative centre sum rounds down
    plan_pair(cells(-256, -1, 0, 256, 6'b000001, 256, 0, 0, 256, 6'b000010), 1,
              portal_at(0, -1, 0));
    plan_pair(cells(0, 0, 0, 0, 6'b000001, 0, 0, 0, 0, 6'b000010), 1, portal_at(0, 0, 0));
    // midpoint clamped to the upper and lower edge of the shared span
    plan_pair(cells(-100, 0, 0, 100, 6'b000001, 950, 1000, 0, 950, 6'b000010), 1,
              portal_at(0, 100, 0));
    plan_pair(cells(-100, 0, 0, 100, 6'b000001, 950, -1000, 0, 950, 6'b000010), 1,
              portal_at(0, -100, 0));
    plan_pair(cells(C_MIN, C_MIN, C_MIN, E_MAX, 6'b111111, C_MAX, C_MAX, C_MAX, E_MAX,
                    6'b111111), 0, NO_PORTAL);
    plan_pair(cells(C_MAX, C_MAX, C_MAX, E_MAX, 6'b111111, C_MIN, C_MIN, C_MIN, E_MAX,
                    6'b111111), 0, NO_PORTAL);
    // face codes that name no face
    plan_setting(FACE_NONE_A, 0, 0);
    plan_pair(cells(-256, 0, 0, 256, 6'b111111, 256, 0, 0, 256, 6'b111111), 1, NO_PORTAL);
    plan_setting(FACE_NONE_B, 0, 0);
    plan_pair(cells(-256, 0, 0, 256, 6'b111111, 256, 0, 0, 256, 6'b111111), 1, NO_PORTAL);
    // every other face, with plane and gap extremes
    plan_setting(FACE_NX, 0, 0);
    plan_pair(cells(256, 0, 0, 256, 6'b000010, -256, 0, 0, 256, 6'b000001), 1, portal_at(0, 0, 0));
    plan_setting(FACE_PY, 1024, 16);
    plan_pair(cells(5, 1000, -3, 20, 6'b000100, 7, 1040, 9, 30, 6'b001000), 0, NO_PORTAL);
    plan_setting(FACE_NY, -4096, 100);
    plan_pair(cells(0, -4000, 0, 64, 6'b001000, 40, -4150, -30, 64, 6'b000100), 0, NO_PORTAL);
    plan_setting(FACE_PZ, C_MAX, E_MAX);
    plan_pair(cells(C_MIN, C_MAX, C_MAX, E_MAX, 6'b111111, C_MAX, C_MIN, C_MAX, 0, 6'b111111),
              0, NO_PORTAL);
    plan_setting(FACE_NZ, C_MIN, E_MAX);
    plan_pair(cells(C_MAX, C_MIN, C_MIN, 0, 6'b100000, C_MIN, C_MAX, C_MIN, E_MAX, 6'b010000),
              0, NO_PORTAL);
    plan_pair(cells(-1, 1, C_MIN, 1, 6'b100000, 0, 0, C_MIN, 1, 6'b010000), 0, NO_PORTAL);

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].set_cfg) begin
        wait_idle();
        write_config(directed_plan[i].face, directed_plan[i].plane, directed_plan[i].gap);
      end
      p = directed_plan[i].pair;
      want = directed_plan[i].known ? directed_plan[i].want : predict_portal(p);
      send_request(p, want);
    end

    // Random phases, each under a fresh setting after a full drain
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      calm = (ph % 4 == 3);
      face = (ph < 8) ? FW'(ph) : FW'($urandom_range(0, FACE_LAST));
      if ($urandom_range(0, 3) == 0) begin
        plane = $urandom;
      end else begin
        plane = CW'($urandom_range(0, 32'h10_0000)) - CW'(32'h8_0000);
      end
      if (ph == 1) plane = C_MIN;
      if (ph == 2) plane = C_MAX;
      gap = ($urandom_range(0, 4) == 0) ? EW'($urandom) : EW'($urandom_range(0, 4096));
      if (ph == 3) gap = '0;
      if (ph == 4) gap = E_MAX;
      write_config(face, plane, gap);
      repeat (PHASE_ITEMS) begin
        p = make_pair($urandom_range(0, 4) == 0);
        send_request(p, predict_portal(p));
      end
    end

    calm = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);
    failures += expected_portals.size();

    $display("Run covered %0d cell pairs under %0d register settings; %0d of %0d results connected.",
             requests_sent, settings_used, portals_found, results_seen);
    $display("Faces included all six plus both unnamed codes, with plane and gap extremes.");
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
